@@ hdl/gsel_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gsel_pkg;

    // Gear counts in use saturate at these limits
    localparam logic [3:0] MAX_FORWARD = 4'd8;
    localparam logic [1:0] MAX_REVERSE = 2'd2;

    typedef enum logic [1:0] {
        MODE_NEUTRAL = 2'd0,
        MODE_DRIVE   = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_PARK    = 2'd3
    } t_mode;

    // Request kinds carried by an item
    localparam logic [1:0] ACT_MODE = 2'd1;
    localparam logic [1:0] ACT_GEAR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_SHIFT_DELAY = 3'd0;
    localparam logic [2:0] CFG_UP_SPEED    = 3'd1;
    localparam logic [2:0] CFG_DOWN_SPEED  = 3'd2;
    localparam logic [2:0] CFG_FWD_COUNT   = 3'd3;
    localparam logic [2:0] CFG_REV_COUNT   = 3'd4;
    localparam logic [2:0] CFG_AUTO_EN     = 3'd5;
    localparam logic [2:0] CFG_DRV_EN      = 3'd6;

    typedef struct packed {
        logic signed [4:0] gear;
        t_mode             mode;
        logic [15:0]       timer;
    } t_pend;

    typedef struct packed {
        t_pend pend;
        logic  ok;
    } t_pick;

    // Request a pending gear; refused when beyond the gears in use.
    function automatic t_pick pick_gear(
        input t_pend             p,
        input logic signed [5:0] g,
        input logic [3:0]        fwd,
        input logic [1:0]        rev,
        input logic [15:0]       delay
    );
        t_pick             r;
        logic signed [6:0] neg;
        logic signed [6:0] fwd7;
        logic signed [6:0] rev7;
        neg    = -{g[5], g};
        fwd7   = {3'b000, fwd};
        rev7   = {5'b00000, rev};
        r.pend = p;
        r.ok   = 1'b1;
        if ({p.gear[4], p.gear} != g) begin
            if (g > 0) begin
                if ({g[5], g} > fwd7) begin
                    r.ok = 1'b0;
                end else begin
                    r.pend.mode  = MODE_DRIVE;
                    r.pend.gear  = g[4:0];
                    r.pend.timer = delay;
                end
            end else if (g < 0) begin
                if (neg > rev7) begin
                    r.ok = 1'b0;
                end else begin
                    r.pend.mode  = MODE_REVERSE;
                    r.pend.gear  = g[4:0];
                    r.pend.timer = delay;
                end
            end else begin
                if (p.mode != MODE_PARK) begin
                    r.pend.mode = MODE_NEUTRAL;
                end
                r.pend.gear  = 5'sd0;
                r.pend.timer = delay;
            end
        end
        return r;
    endfunction

    // Request a mode; drive and reverse pick first gear only when needed.
    function automatic t_pick pick_mode(
        input t_pend             p,
        input t_mode             m,
        input logic signed [5:0] eng,
        input logic [3:0]        fwd,
        input logic [1:0]        rev,
        input logic [15:0]       delay
    );
        t_pick r;
        t_pend q;
        q      = p;
        r.pend = p;
        r.ok   = 1'b1;
        if (m != p.mode) begin
            q.mode = m;
            r.pend = q;
            if (m == MODE_DRIVE) begin
                if (eng <= 0) begin
                    r = pick_gear(q, 6'sd1, fwd, rev, delay);
                end
            end else if (m == MODE_REVERSE) begin
                if (eng >= 0) begin
                    r = pick_gear(q, -6'sd1, fwd, rev, delay);
                end
            end else begin
                r = pick_gear(q, 6'sd0, fwd, rev, delay);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/gear_selector_with_shift_delay_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Gear selector with shift delay. Each item is one time tick: it may carry a
// driver request (mode or gear number, up/down presses), the output shaft
// speed and the time elapsed since the previous tick. The tick applies the
// driver request (when enabled), then an automatic up/down shift against the
// speed thresholds while engaged in drive, then runs the shift timer down by
// the elapsed time; when the timer runs out the pending gear and mode become
// engaged. Exactly one result item comes out per tick item, in order.
// Rate: one item per clock cycle sustained while results are taken. The item
// lands in the input register, and from there the single-pass update of the
// gear/mode/timer registers writes the result register. The feedback through
// the engaged/pending state registers is what limits the rate to one item per
// cycle. A stalled result holds the result register and, once the input
// register is also full, input ready drops.
// Configuration: write index/data on the cfg channel (always ready) while no
// item is in flight. Indexes: 0 shift delay, 1 upshift speed, 2 downshift
// speed, 3 forward gear count, 4 reverse gear count, 5 auto shift enable,
// 6 driver input enable; index 7 is ignored.

module gear_selector_with_shift_delay_core
    import gsel_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,

    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_action,
    input  wire logic [1:0]         i_requested_mode,
    input  wire logic signed [4:0]  i_requested_gear,
    input  wire logic               i_up_pressed,
    input  wire logic               i_down_pressed,
    input  wire logic [15:0]        i_output_speed,
    input  wire logic [15:0]        i_elapsed_time,

    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [4:0]       o_current_gear,
    output logic [1:0]              o_current_mode,
    output logic signed [4:0]       o_target_gear,
    output logic [1:0]              o_target_mode,
    output logic                    o_shifting,
    output logic                    o_request_ok
);

    // Configuration registers
    logic [15:0] r_shift_delay;
    logic [15:0] r_up_speed;
    logic [15:0] r_down_speed;
    logic [3:0]  r_fwd_count;
    logic [1:0]  r_rev_count;
    logic        r_auto_en;
    logic        r_drv_en;

    // Input register
    logic              r_in_valid;
    logic [1:0]        r_action;
    t_mode             r_req_mode;
    logic signed [4:0] r_req_gear;
    logic              r_up;
    logic              r_down;
    logic [15:0]       r_speed;
    logic [15:0]       r_elapsed;

    // Gear state
    logic signed [4:0] r_eng_gear;
    t_mode             r_eng_mode;
    t_pend             r_pend;

    // Result register
    logic              r_out_valid;
    logic signed [4:0] r_out_cur_gear;
    t_mode             r_out_cur_mode;
    logic signed [4:0] r_out_tgt_gear;
    t_mode             r_out_tgt_mode;
    logic              r_out_shifting;
    logic              r_out_ok;

    logic              w_adv;
    logic [3:0]        w_fwd;
    logic [1:0]        w_rev;
    logic signed [5:0] w_fwd6;
    logic signed [5:0] w_eng6;
    logic signed [5:0] w_req6;
    t_pick             w_pk;
    t_pend             w_pend;
    logic              w_ok;

    logic signed [4:0] n_eng_gear;
    t_mode             n_eng_mode;
    t_pend             n_pend;
    logic              n_shifting;

    // Item moves from input register to result register when the result
    // register is free or being drained this cycle.
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    // Gear counts in use, saturated
    assign w_fwd  = (r_fwd_count > MAX_FORWARD) ? MAX_FORWARD : r_fwd_count;
    assign w_rev  = (r_rev_count > MAX_REVERSE) ? MAX_REVERSE : r_rev_count;
    assign w_fwd6 = {2'b00, w_fwd};
    assign w_eng6 = {r_eng_gear[4], r_eng_gear};
    assign w_req6 = {r_req_gear[4], r_req_gear};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_delay <= 16'd0;
            r_up_speed    <= 16'd0;
            r_down_speed  <= 16'd0;
            r_fwd_count   <= 4'd1;
            r_rev_count   <= 2'd1;
            r_auto_en     <= 1'b0;
            r_drv_en      <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SHIFT_DELAY: r_shift_delay <= i_cfg_data;
                CFG_UP_SPEED:    r_up_speed    <= i_cfg_data;
                CFG_DOWN_SPEED:  r_down_speed  <= i_cfg_data;
                CFG_FWD_COUNT:   r_fwd_count   <= i_cfg_data[3:0];
                CFG_REV_COUNT:   r_rev_count   <= i_cfg_data[1:0];
                CFG_AUTO_EN:     r_auto_en     <= i_cfg_data[0];
                CFG_DRV_EN:      r_drv_en      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action   <= i_action;
            r_req_mode <= t_mode'(i_requested_mode);
            r_req_gear <= i_requested_gear;
            r_up       <= i_up_pressed;
            r_down     <= i_down_pressed;
            r_speed    <= i_output_speed;
            r_elapsed  <= i_elapsed_time;
        end
    end

    // One tick: driver request, automatic shift, then shift timer.
    // Each pick sees the pending state left by the one before it.
    always_comb begin
        w_pend = r_pend;
        w_ok   = 1'b1;
        w_pk   = '{pend: r_pend, ok: 1'b1};

        if (r_drv_en) begin
            if (r_action == ACT_MODE && r_eng_mode != r_req_mode) begin
                w_pk   = pick_mode(w_pend, r_req_mode, w_eng6, w_fwd, w_rev, r_shift_delay);
                w_pend = w_pk.pend;
                w_ok   = w_ok & w_pk.ok;
            end
            if (r_action == ACT_GEAR && w_eng6 != w_req6) begin
                w_pk   = pick_gear(w_pend, w_req6, w_fwd, w_rev, r_shift_delay);
                w_pend = w_pk.pend;
                w_ok   = w_ok & w_pk.ok;
            end
            if (r_up && w_eng6 >= 0 && w_eng6 < w_fwd6) begin
                w_pk   = pick_gear(w_pend, w_eng6 + 6'sd1, w_fwd, w_rev, r_shift_delay);
                w_pend = w_pk.pend;
                w_ok   = w_ok & w_pk.ok;
            end
            if (r_down && w_eng6 > 0) begin
                w_pk   = pick_gear(w_pend, w_eng6 - 6'sd1, w_fwd, w_rev, r_shift_delay);
                w_pend = w_pk.pend;
                w_ok   = w_ok & w_pk.ok;
            end
        end

        if (r_auto_en && r_eng_mode == MODE_DRIVE) begin
            if (r_speed > r_up_speed) begin
                if (w_eng6 < w_fwd6) begin
                    w_pk   = pick_gear(w_pend, w_eng6 + 6'sd1, w_fwd, w_rev, r_shift_delay);
                    w_pend = w_pk.pend;
                    w_ok   = w_ok & w_pk.ok;
                end
            end else if (r_speed < r_down_speed) begin
                if (w_eng6 > 6'sd1) begin
                    w_pk   = pick_gear(w_pend, w_eng6 - 6'sd1, w_fwd, w_rev, r_shift_delay);
                    w_pend = w_pk.pend;
                    w_ok   = w_ok & w_pk.ok;
                end
            end
        end

        // Shift timer runs only while pending differs from engaged
        n_pend     = w_pend;
        n_eng_gear = r_eng_gear;
        n_eng_mode = r_eng_mode;
        if (r_eng_gear != w_pend.gear || r_eng_mode != w_pend.mode) begin
            if (r_elapsed >= w_pend.timer) begin
                n_pend.timer = 16'd0;
                n_eng_gear   = w_pend.gear;
                n_eng_mode   = w_pend.mode;
            end else begin
                n_pend.timer = w_pend.timer - r_elapsed;
            end
        end
        n_shifting = (n_eng_gear != n_pend.gear) || (n_eng_mode != n_pend.mode);
    end

    // Gear state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng_gear <= 5'sd0;
            r_eng_mode <= MODE_NEUTRAL;
            r_pend     <= '{gear: 5'sd0, mode: MODE_NEUTRAL, timer: 16'd0};
        end else if (w_adv) begin
            r_eng_gear <= n_eng_gear;
            r_eng_mode <= n_eng_mode;
            r_pend     <= n_pend;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_cur_gear <= n_eng_gear;
            r_out_cur_mode <= n_eng_mode;
            r_out_tgt_gear <= n_pend.gear;
            r_out_tgt_mode <= n_pend.mode;
            r_out_shifting <= n_shifting;
            r_out_ok       <= w_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_current_gear = r_out_cur_gear;
    assign o_current_mode = r_out_cur_mode;
    assign o_target_gear  = r_out_tgt_gear;
    assign o_target_mode  = r_out_tgt_mode;
    assign o_shifting     = r_out_shifting;
    assign o_request_ok   = r_out_ok;

    // Engaged gear never leaves the range of gears that exist
    a_eng_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eng_gear <= $signed({1'b0, MAX_FORWARD})) &&
        (r_eng_gear >= -$signed({3'b000, MAX_REVERSE})))
        else $error("engaged gear out of range");

    // Gear state moves only when an item is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_eng_gear) && $stable(r_eng_mode) && $stable(r_pend)))
        else $error("gear state changed without an item");

    // A processed item always produces a result next cycle
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed item produced no result");

    // Full input register behind a stalled result blocks new items
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline is full and stalled");

endmodule

`default_nettype wire

@@ test/gear_tick_checker.sv @@
`timescale 1ns / 1ps

// Watches the cfg, tick and result channels of the gear selector, keeps its
// own copy of the gear/mode/timer state and the registers, predicts one result
// per accepted tick item and compares it with the oldest prediction.
module gear_tick_checker
    import gsel_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,

    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_action,
    input  logic [1:0]        i_requested_mode,
    input  logic signed [4:0] i_requested_gear,
    input  logic              i_up_pressed,
    input  logic              i_down_pressed,
    input  logic [15:0]       i_output_speed,
    input  logic [15:0]       i_elapsed_time,

    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic signed [4:0] i_current_gear,
    input  logic [1:0]        i_current_mode,
    input  logic signed [4:0] i_target_gear,
    input  logic [1:0]        i_target_mode,
    input  logic              i_shifting,
    input  logic              i_request_ok,

    output int                o_mismatch_count,
    output int                o_outstanding
);

    typedef struct packed {
        logic signed [4:0] cur_gear;
        t_mode             cur_mode;
        logic signed [4:0] tgt_gear;
        t_mode             tgt_mode;
        logic              shifting;
        logic              req_ok;
    } tick_result_t;

    tick_result_t expected_ticks[$];

    // registers
    logic [15:0] cfg_delay, cfg_up, cfg_down;
    logic [3:0]  cfg_fwd;
    logic [1:0]  cfg_rev;
    logic        cfg_auto, cfg_drv;

    // gear state
    logic signed [4:0] eng_gear, pend_gear;
    t_mode             eng_mode, pend_mode;
    logic [15:0]       shift_timer;

    function automatic int fwd_limit();
        return (cfg_fwd > MAX_FORWARD) ? int'(MAX_FORWARD) : int'(cfg_fwd);
    endfunction

    function automatic int rev_limit();
        return (cfg_rev > MAX_REVERSE) ? int'(MAX_REVERSE) : int'(cfg_rev);
    endfunction

    // new pending gear; refused beyond the gears in use
    function automatic bit claim_gear(input int g);
        if (int'(pend_gear) == g) return 1'b1;
        if (g > 0) begin
            if (g > fwd_limit()) return 1'b0;
            pend_mode = MODE_DRIVE;
        end else if (g < 0) begin
            if (-g > rev_limit()) return 1'b0;
            pend_mode = MODE_REVERSE;
        end else if (pend_mode != MODE_PARK) begin
            pend_mode = MODE_NEUTRAL;
        end
        pend_gear   = 5'(g);
        shift_timer = cfg_delay;
        return 1'b1;
    endfunction

    // mode change sticks even when the gear it needs is refused
    function automatic bit claim_mode(input t_mode m);
        if (m == pend_mode) return 1'b1;
        pend_mode = m;
        if (m == MODE_DRIVE) return (int'(eng_gear) <= 0) ? claim_gear(1) : 1'b1;
        if (m == MODE_REVERSE) return (int'(eng_gear) >= 0) ? claim_gear(-1) : 1'b1;
        return claim_gear(0);
    endfunction

    function automatic tick_result_t predict_tick(
        input logic [1:0]        act,
        input logic [1:0]        req_mode,
        input logic signed [4:0] req_gear,
        input logic              up,
        input logic              dn,
        input logic [15:0]       speed,
        input logic [15:0]       elapsed
    );
        tick_result_t r;
        bit           ok;
        int           eng;
        ok  = 1'b1;
        eng = int'(eng_gear);
        if (cfg_drv) begin
            if (act == ACT_MODE && eng_mode != t_mode'(req_mode))
                ok = claim_mode(t_mode'(req_mode)) && ok;
            if (act == ACT_GEAR && eng != int'(req_gear))
                ok = claim_gear(int'(req_gear)) && ok;
            if (up && eng >= 0 && eng < fwd_limit())
                ok = claim_gear(eng + 1) && ok;
            if (dn && eng > 0)
                ok = claim_gear(eng - 1) && ok;
        end
        if (cfg_auto && eng_mode == MODE_DRIVE) begin
            if (speed > cfg_up) begin
                if (eng < fwd_limit()) ok = claim_gear(eng + 1) && ok;
            end else if (speed < cfg_down) begin
                if (eng > 1) ok = claim_gear(eng - 1) && ok;
            end
        end
        if (eng_gear != pend_gear || eng_mode != pend_mode) begin
            if (elapsed >= shift_timer) begin
                shift_timer = '0;
                eng_gear    = pend_gear;
                eng_mode    = pend_mode;
            end else begin
                shift_timer = shift_timer - elapsed;
            end
        end
        r.cur_gear = eng_gear;
        r.cur_mode = eng_mode;
        r.tgt_gear = pend_gear;
        r.tgt_mode = pend_mode;
        r.shifting = (eng_gear != pend_gear) || (eng_mode != pend_mode);
        r.req_ok   = ok;
        return r;
    endfunction

    always @(posedge i_clk) begin
        tick_result_t got, want;
        if (!i_rst_n) begin
            cfg_delay   = '0;
            cfg_up      = '0;
            cfg_down    = '0;
            cfg_fwd     = 4'd1;
            cfg_rev     = 2'd1;
            cfg_auto    = 1'b0;
            cfg_drv     = 1'b1;
            eng_gear    = '0;
            pend_gear   = '0;
            eng_mode    = MODE_NEUTRAL;
            pend_mode   = MODE_NEUTRAL;
            shift_timer = '0;
            expected_ticks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SHIFT_DELAY: cfg_delay = i_cfg_data;
                    CFG_UP_SPEED:    cfg_up    = i_cfg_data;
                    CFG_DOWN_SPEED:  cfg_down  = i_cfg_data;
                    CFG_FWD_COUNT:   cfg_fwd   = i_cfg_data[3:0];
                    CFG_REV_COUNT:   cfg_rev   = i_cfg_data[1:0];
                    CFG_AUTO_EN:     cfg_auto  = i_cfg_data[0];
                    CFG_DRV_EN:      cfg_drv   = i_cfg_data[0];
                    default: ;
                endcase
            end
            // result first: it can only belong to an item from an earlier edge
            if (i_out_valid && i_out_ready) begin
                got.cur_gear = i_current_gear;
                got.cur_mode = t_mode'(i_current_mode);
                got.tgt_gear = i_target_gear;
                got.tgt_mode = t_mode'(i_target_mode);
                got.shifting = i_shifting;
                got.req_ok   = i_request_ok;
                if (expected_ticks.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= 10)
                        $display("%0t: result item with no tick pending: gear %0d mode %0d",
                                 $realtime, got.cur_gear, got.cur_mode);
                end else begin
                    want = expected_ticks.pop_front();
                    if (got !== want) begin
                        o_mismatch_count++;
                        if (o_mismatch_count <= 10) begin
                            $display("%0t: mismatch exp cur %0d/%0d tgt %0d/%0d shf %0b ok %0b",
                                     $realtime, want.cur_gear, want.cur_mode, want.tgt_gear,
                                     want.tgt_mode, want.shifting, want.req_ok);
                            $display("    got cur %0d/%0d tgt %0d/%0d shf %0b ok %0b",
                                     got.cur_gear, got.cur_mode, got.tgt_gear,
                                     got.tgt_mode, got.shifting, got.req_ok);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_ticks.push_back(predict_tick(i_action, i_requested_mode,
                    i_requested_gear, i_up_pressed, i_down_pressed,
                    i_output_speed, i_elapsed_time));
        end
        o_outstanding = expected_ticks.size();
    end

endmodule

@@ test/gear_selector_with_shift_delay_core_tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the gear selector. The checker beside the DUT
// does all prediction and comparison; this module only drives items,
// programs registers between phases and decides pass/fail.
module gear_selector_with_shift_delay_core_tb;
    import gsel_pkg::*;

    // request kinds the package does not name
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_SKIP = 2'd3;   // unused code, behaves as no request
    localparam logic [2:0] CFG_SPARE = 3'd7;  // unmapped register index

    localparam int QUIET_LIMIT     = 4000;    // cycles with no handshake at all
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 105;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [2:0]        i_cfg_index = '0;
    logic [15:0]       i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic [1:0]        i_action = '0;
    logic [1:0]        i_requested_mode = '0;
    logic signed [4:0] i_requested_gear = '0;
    logic              i_up_pressed = 1'b0;
    logic              i_down_pressed = 1'b0;
    logic [15:0]       i_output_speed = '0;
    logic [15:0]       i_elapsed_time = '0;
    logic              i_out_ready = 1'b0;

    logic              o_cfg_ready, o_in_ready, o_out_valid;
    logic signed [4:0] o_current_gear, o_target_gear;
    logic [1:0]        o_current_mode, o_target_mode;
    logic              o_shifting, o_request_ok;

    int mismatches;
    int outstanding;

    // current register values, used to aim speed and elapsed time
    logic [15:0] delay_now = '0, up_now = '0, down_now = '0;

    int burst_left  = 0;
    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    gear_selector_with_shift_delay_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_requested_mode (i_requested_mode),
        .i_requested_gear (i_requested_gear),
        .i_up_pressed     (i_up_pressed),
        .i_down_pressed   (i_down_pressed),
        .i_output_speed   (i_output_speed),
        .i_elapsed_time   (i_elapsed_time),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_current_gear   (o_current_gear),
        .o_current_mode   (o_current_mode),
        .o_target_gear    (o_target_gear),
        .o_target_mode    (o_target_mode),
        .o_shifting       (o_shifting),
        .o_request_ok     (o_request_ok)
    );

    gear_tick_checker tick_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_requested_mode (i_requested_mode),
        .i_requested_gear (i_requested_gear),
        .i_up_pressed     (i_up_pressed),
        .i_down_pressed   (i_down_pressed),
        .i_output_speed   (i_output_speed),
        .i_elapsed_time   (i_elapsed_time),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_current_gear   (o_current_gear),
        .i_current_mode   (o_current_mode),
        .i_target_gear    (o_target_gear),
        .i_target_mode    (o_target_mode),
        .i_shifting       (o_shifting),
        .i_request_ok     (o_request_ok),
        .o_mismatch_count (mismatches),
        .o_outstanding    (outstanding)
    );

    // Result backpressure: switches between always ready, coin-flip ready
    // and long alternating stall/ready runs, each style held for a while.
    int ready_style = 0;
    int style_left  = 0;
    int stall_run   = 0;
    always @(negedge i_clk) begin
        if (style_left == 0) begin
            ready_style <= $urandom_range(0, 2);
            style_left  <= $urandom_range(40, 250);
        end else begin
            style_left <= style_left - 1;
        end
        case (ready_style)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_run == 0) begin
                    i_out_ready <= ~i_out_ready;
                    stall_run   <= $urandom_range(1, 24);
                end else begin
                    stall_run <= stall_run - 1;
                end
            end
        endcase
    end

    // Watchdog: any handshake on any channel clears the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("gear_selector_with_shift_delay_core regression: fail");
        $finish;
    end

    // One tick item. Valid stays up across a burst; at a burst end the
    // line may drop for a random gap and a new burst length is drawn.
    task automatic send_tick(
        input logic [1:0]        act,
        input logic [1:0]        mode,
        input logic signed [4:0] gear,
        input logic              up,
        input logic              dn,
        input logic [15:0]       speed,
        input logic [15:0]       elapsed
    );
        int gap;
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_requested_mode <= mode;
        i_requested_gear <= gear;
        i_up_pressed     <= up;
        i_down_pressed   <= dn;
        i_output_speed   <= speed;
        i_elapsed_time   <= elapsed;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 16);
        end
    endtask

    // Register write; valid is left up so that a group goes back to back.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Narrow registers get random upper data bits; only the low bits count.
    task automatic program_regs(
        input logic [15:0] dly,
        input logic [15:0] up,
        input logic [15:0] dn,
        input logic [3:0]  fwd,
        input logic [1:0]  rev,
        input logic        auto_en,
        input logic        drv_en
    );
        write_reg(CFG_SHIFT_DELAY, dly);
        write_reg(CFG_UP_SPEED, up);
        write_reg(CFG_DOWN_SPEED, dn);
        write_reg(CFG_FWD_COUNT, {12'($urandom), fwd});
        write_reg(CFG_REV_COUNT, {14'($urandom), rev});
        write_reg(CFG_AUTO_EN, {15'($urandom), auto_en});
        write_reg(CFG_DRV_EN, {15'($urandom), drv_en});
        i_cfg_valid <= 1'b0;
        delay_now = dly;
        up_now    = up;
        down_now  = dn;
    endtask

    // Drain: stop sending, wait for every predicted result, then let the
    // two-stage pipe go quiet.
    task automatic settle(input int tail);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    task automatic program_random();
        logic [15:0] dly, up, dn;
        logic [3:0]  fwd;
        case ($urandom_range(0, 5))
            0: dly = 16'd0;
            1: dly = 16'hFFFF;
            2: dly = 16'($urandom_range(1, 8));
            3: dly = 16'($urandom_range(9, 64));
            default: dly = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: up = 16'd0;
            1: up = 16'hFFFF;
            default: up = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: dn = 16'd0;
            1: dn = 16'hFFFF;
            2: dn = 16'($urandom);
            default: dn = 16'($urandom_range(0, int'(up)));
        endcase
        fwd = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
        program_regs(dly, up, dn, fwd, 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 5) != 0));
    endtask

    // Random tick: gears mostly in the useful band, speed often right at a
    // threshold, elapsed time scaled to the delay so shifts do complete.
    task automatic random_tick();
        logic [1:0]        act;
        logic signed [4:0] gear;
        logic [15:0]       spd, el;
        int                pick, s;
        pick = $urandom_range(0, 19);
        if (pick < 6)       act = ACT_NONE;
        else if (pick < 11) act = ACT_MODE;
        else if (pick < 17) act = ACT_GEAR;
        else                act = ACT_SKIP;
        if ($urandom_range(0, 4) == 0) gear = 5'($urandom);
        else                           gear = 5'(int'($urandom_range(0, 12)) - 3);
        case ($urandom_range(0, 5))
            0: spd = 16'd0;
            1: spd = 16'hFFFF;
            2: spd = 16'($urandom);
            default: begin
                s = (($urandom_range(0, 1) == 0) ? int'(up_now) : int'(down_now))
                    + int'($urandom_range(0, 4)) - 2;
                if (s < 0) s = 0;
                if (s > 65535) s = 65535;
                spd = 16'(s);
            end
        endcase
        case ($urandom_range(0, 5))
            0: el = 16'd0;
            1: el = 16'($urandom_range(1, 16));
            2: el = 16'($urandom);
            3: el = 16'hFFFF;
            default: el = 16'($urandom_range(0, int'(delay_now)));
        endcase
        send_tick(act, 2'($urandom), gear, 1'($urandom_range(0, 9) < 3),
                  1'($urandom_range(0, 9) < 3), spd, el);
    endtask

    initial begin
        int ph;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed: saturating counts, delay 5, no auto shift ----
        write_reg(CFG_SPARE, 16'hFFFF);   // unmapped index, must be ignored
        program_regs(16'd5, 16'hFFFF, 16'd0, 4'd15, 2'd3, 1'b0, 1'b1);
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'd0, 16'd0);
        send_tick(ACT_MODE, MODE_DRIVE, 0, 0, 0, 16'd0, 16'd0);       // drive picks gear 1
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'd0, 16'd5);     // elapsed equals timer
        send_tick(ACT_GEAR, MODE_NEUTRAL, 8, 0, 0, 16'hFFFF, 16'hFFFF); // top gear
        send_tick(ACT_GEAR, MODE_NEUTRAL, 9, 0, 0, 16'd0, 16'd0);     // beyond saturated count
        send_tick(ACT_GEAR, MODE_PARK, 15, 0, 0, 16'd0, 16'd0);
        send_tick(ACT_GEAR, MODE_NEUTRAL, -16, 0, 0, 16'd0, 16'd0);   // beyond reverse count
        send_tick(ACT_GEAR, MODE_NEUTRAL, -2, 0, 0, 16'd0, 16'd0);
        send_tick(ACT_GEAR, MODE_NEUTRAL, -2, 0, 0, 16'd0, 16'd2);    // already pending
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'd0, 16'd3);
        send_tick(ACT_MODE, MODE_REVERSE, 0, 0, 0, 16'd0, 16'd0);     // same mode, no-op
        send_tick(ACT_MODE, MODE_DRIVE, 0, 0, 0, 16'd0, 16'hFFFF);
        send_tick(ACT_MODE, MODE_REVERSE, 0, 0, 0, 16'd0, 16'd1);
        send_tick(ACT_SKIP, MODE_PARK, -1, 1, 0, 16'd0, 16'hFFFF);    // unused code, up still works
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 1, 16'd0, 16'd5);     // down press
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 1, 1, 16'd0, 16'd0);     // both presses
        send_tick(ACT_MODE, MODE_PARK, 0, 0, 0, 16'd0, 16'hFFFF);     // park kept as pending mode
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 1, 0, 16'd0, 16'd0);
        send_tick(ACT_MODE, MODE_NEUTRAL, 0, 0, 0, 16'd0, 16'hFFFF);

        // ---- directed: no reverse gears, one forward, longest delay ----
        settle(4);
        program_regs(16'hFFFF, 16'hFFFF, 16'd0, 4'd1, 2'd0, 1'b0, 1'b1);
        send_tick(ACT_MODE, MODE_REVERSE, 0, 0, 0, 16'd0, 16'd0);     // gear refused, mode kept
        send_tick(ACT_GEAR, MODE_NEUTRAL, 2, 1, 0, 16'd0, 16'd65534);
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'd0, 16'd1);

        // ---- directed: automatic shifting around the thresholds ----
        settle(4);
        program_regs(16'd0, 16'd100, 16'd50, 4'd8, 2'd2, 1'b1, 1'b1);
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'hFFFF, 16'd0);
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'd101, 16'd0);
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'd49, 16'd0);
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'd0, 16'd0);
        send_tick(ACT_NONE, MODE_NEUTRAL, 0, 0, 0, 16'd0, 16'd0);     // gear 1 holds
        settle(4);
        write_reg(CFG_DRV_EN, 16'h0000);
        i_cfg_valid <= 1'b0;
        send_tick(ACT_GEAR, MODE_REVERSE, -2, 1, 1, 16'd101, 16'd0);  // driver ignored

        // ---- random phases, fresh register settings each time ----
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle(4);
            program_random();
            repeat (TICKS_PER_PHASE) random_tick();
        end

        settle(8);
        if (mismatches == 0 && outstanding == 0)
            $display("gear_selector_with_shift_delay_core regression: pass");
        else
            $display("gear_selector_with_shift_delay_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
hdl/gsel_pkg.sv
hdl/gear_selector_with_shift_delay_core.sv
test/gear_tick_checker.sv
test/gear_selector_with_shift_delay_core_tb.sv
